>>> rtl/core/aesp_pkg.sv
// ----------------------------------------------------------------------------
// aesp_pkg
// Shared types, character codes and command codes of the escape sequence
// parser.
// ----------------------------------------------------------------------------
package aesp_pkg;

    localparam int PARAM_BITS = 16;
    localparam int OUT_PARAM_W = 16;
    localparam int CMD_W = 5;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_7    = 8'h37;
    localparam logic [7:0] CH_8    = 8'h38;
    localparam logic [7:0] CH_LS   = 8'h73;
    localparam logic [7:0] CH_LU   = 8'h75;
    localparam logic [7:0] CH_J    = 8'h4A;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_LM   = 8'h6D;

    localparam logic [CMD_W-1:0] CMD_UP                = 5'd0;
    localparam logic [CMD_W-1:0] CMD_DOWN              = 5'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT             = 5'd2;
    localparam logic [CMD_W-1:0] CMD_LEFT              = 5'd3;
    localparam logic [CMD_W-1:0] CMD_NEXTLINE          = 5'd4;
    localparam logic [CMD_W-1:0] CMD_PREVLINE          = 5'd5;
    localparam logic [CMD_W-1:0] CMD_COLUMN            = 5'd6;
    localparam logic [CMD_W-1:0] CMD_HOME              = 5'd7;
    localparam logic [CMD_W-1:0] CMD_MOVETO            = 5'd8;
    localparam logic [CMD_W-1:0] CMD_LINEUP            = 5'd9;
    localparam logic [CMD_W-1:0] CMD_SAVE              = 5'd10;
    localparam logic [CMD_W-1:0] CMD_RESTORE           = 5'd11;
    localparam logic [CMD_W-1:0] CMD_ERASE_SCREEN_BASE = 5'd12;
    localparam logic [CMD_W-1:0] CMD_ERASE_LINE_BASE   = 5'd16;
    localparam logic [CMD_W-1:0] CMD_STYLE             = 5'd19;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_ESC    = 4'b0010,
        PH_FIRST  = 4'b0100,
        PH_SECOND = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [PARAM_BITS-1:0] first_value;
        logic                  first_seen;
        logic [PARAM_BITS-1:0] second_value;
        logic                  second_seen;
    } parse_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [OUT_PARAM_W-1:0] first_param;
        logic                   first_present;
        logic [OUT_PARAM_W-1:0] second_param;
        logic                   second_present;
    } result_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [PARAM_BITS-1:0] accumulate(
        input logic [PARAM_BITS-1:0] acc,
        input logic [7:0]            b
    );
        logic [PARAM_BITS+3:0] wide;
        wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1)
             + (PARAM_BITS+4)'(b[3:0]);
        if (|wide[PARAM_BITS+3:PARAM_BITS]) begin
            return {PARAM_BITS{1'b1}};
        end
        return wide[PARAM_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/aesp_step.sv
// ----------------------------------------------------------------------------
// aesp_step
// Next parser state and optional command for one received byte.
// ----------------------------------------------------------------------------
module aesp_step (
    input  aesp_pkg::parse_state_t cur_state,
    input  logic [7:0]             rx_byte,
    output aesp_pkg::parse_state_t next_state,
    output logic                   emit,
    output aesp_pkg::result_t      result
);
    import aesp_pkg::*;

    logic                  take_final;
    logic                  cmd_ok;
    logic [CMD_W-1:0]      cmd;
    logic [PARAM_BITS-1:0] arg;

    always_comb begin
        next_state = cur_state;
        take_final = 1'b0;
        unique case (cur_state.phase)
            PH_IDLE: begin
                if (rx_byte == CH_ESC) begin
                    next_state.phase        = PH_ESC;
                    next_state.first_value  = '0;
                    next_state.first_seen   = 1'b0;
                    next_state.second_value = '0;
                    next_state.second_seen  = 1'b0;
                end
            end
            PH_ESC: begin
                if (rx_byte == CH_LBR) begin
                    next_state.phase = PH_FIRST;
                end else begin
                    take_final = 1'b1;
                end
            end
            PH_FIRST: begin
                priority if (is_digit(rx_byte)) begin
                    next_state.first_value = accumulate(cur_state.first_value, rx_byte);
                    next_state.first_seen  = 1'b1;
                end else if (rx_byte == CH_SEMI) begin
                    next_state.second_seen = 1'b1;
                    next_state.phase       = PH_SECOND;
                end else begin
                    take_final = 1'b1;
                end
            end
            PH_SECOND: begin
                if (is_digit(rx_byte)) begin
                    next_state.second_value = accumulate(cur_state.second_value, rx_byte);
                end else begin
                    take_final = 1'b1;
                end
            end
            default: begin
                next_state.phase = PH_IDLE;
            end
        endcase
        if (take_final) begin
            next_state.phase = PH_IDLE;
        end
    end

    assign arg = cur_state.first_seen ? cur_state.first_value : '0;

    always_comb begin
        cmd    = CMD_UP;
        cmd_ok = 1'b1;
        unique case (rx_byte)
            CH_A:  cmd = CMD_UP;
            CH_B:  cmd = CMD_DOWN;
            CH_C:  cmd = CMD_RIGHT;
            CH_D:  cmd = CMD_LEFT;
            CH_E:  cmd = CMD_NEXTLINE;
            CH_F:  cmd = CMD_PREVLINE;
            CH_G:  cmd = CMD_COLUMN;
            CH_H:  cmd = cur_state.first_seen ? CMD_MOVETO : CMD_HOME;
            CH_LF: cmd = CMD_MOVETO;
            CH_M:  cmd = CMD_LINEUP;
            CH_7, CH_LS: cmd = CMD_SAVE;
            CH_8, CH_LU: cmd = CMD_RESTORE;
            CH_J: begin
                cmd_ok = (arg <= PARAM_BITS'(3));
                cmd    = CMD_ERASE_SCREEN_BASE + CMD_W'(arg[1:0]);
            end
            CH_K: begin
                cmd_ok = (arg <= PARAM_BITS'(2));
                cmd    = CMD_ERASE_LINE_BASE + CMD_W'(arg[1:0]);
            end
            CH_LM: cmd = CMD_STYLE;
            default: cmd_ok = 1'b0;
        endcase
    end

    assign emit                  = take_final && cmd_ok;
    assign result.command        = cmd;
    assign result.first_param    = OUT_PARAM_W'(arg);
    assign result.first_present  = cur_state.first_seen;
    assign result.second_param   = cur_state.second_seen ?
                                   OUT_PARAM_W'(cur_state.second_value) : '0;
    assign result.second_present = cur_state.second_seen;

endmodule

>>> rtl/core/ansi_escape_sequence_parser.sv
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser
// Byte-wide parser of terminal escape sequences that emits cursor, erase
// and style commands.
// ----------------------------------------------------------------------------
// Bytes of the terminal stream enter on the s_ channel, one per transaction.
// Each byte updates the parser state in the cycle it is accepted; a byte
// that completes a valid sequence loads one command transaction, with both
// numeric arguments and their presence flags, into the m_ output register,
// or into the skid register while that is occupied. The command is offered
// on m_valid from the output register, and one byte is accepted in every
// cycle as long as the receiver keeps up.
// A one-entry skid register stands behind the output register. While the
// receiver stalls, bytes keep being accepted; the first command that finds
// the output register occupied waits in the skid register, and s_ready falls
// only while the skid register is full. It rises again once the receiver
// takes the output.
// Synchronous reset returns the parser to idle, clears both arguments and
// drops all pending commands.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [aesp_pkg::CMD_W-1:0]       m_command,
    output logic [aesp_pkg::OUT_PARAM_W-1:0] m_first_param,
    output logic                             m_first_present,
    output logic [aesp_pkg::OUT_PARAM_W-1:0] m_second_param,
    output logic                             m_second_present
);
    import aesp_pkg::*;

    parse_state_t state_reg, state_next;
    parse_state_t step_state;
    result_t      out_reg, out_next;
    result_t      skid_reg, skid_next;
    result_t      step_result;
    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    logic         step_emit;
    logic         in_fire;
    logic         out_fire;

    aesp_step u_step (
        .cur_state  (state_reg),
        .rx_byte    (s_rx_byte),
        .next_state (step_state),
        .emit       (step_emit),
        .result     (step_result)
    );

    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_fire = out_valid_reg && m_ready;

    always_comb begin
        state_next      = in_fire ? step_state : state_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire) begin
            out_next        = skid_reg;
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (in_fire && step_emit) begin
            if (!out_valid_next) begin
                out_next       = step_result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = step_result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= PH_IDLE;
            state_reg.first_value  <= '0;
            state_reg.first_seen   <= 1'b0;
            state_reg.second_value <= '0;
            state_reg.second_seen  <= 1'b0;
            out_valid_reg          <= 1'b0;
            skid_valid_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_command        = out_reg.command;
    assign m_first_param    = out_reg.first_param;
    assign m_first_present  = out_reg.first_present;
    assign m_second_param   = out_reg.second_param;
    assign m_second_present = out_reg.second_present;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a command while the output is empty");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && step_emit && out_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("command produced during a stall was not kept");

    a_esc_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && state_reg.phase == PH_IDLE && s_rx_byte == CH_ESC)
        |=> (state_reg.phase == PH_ESC && !state_reg.first_seen
             && !state_reg.second_seen))
        else $error("escape byte did not open a clean sequence");

    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_command <= CMD_STYLE))
        else $error("command code out of range");

    a_present_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_second_present) |-> (m_second_param == '0))
        else $error("absent second argument is not zero");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the terminal escape sequence parser.
// ----------------------------------------------------------------------------
// A byte stream is driven into the s_ channel with bursts and gaps, while the
// m_ channel stalls on a pattern of its own. A behavioral copy of the parser
// tracks every accepted byte and queues the command it should produce, and
// each command transaction is compared field by field with the oldest queued
// one. The stimulus is a directed set of corner cases, then mostly
// well-formed sequences with random arguments mixed with noise, and one
// long receiver hold that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aesp_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_rx_byte;
    logic                   m_valid;
    logic                   m_ready;
    logic [CMD_W-1:0]       m_command;
    logic [OUT_PARAM_W-1:0] m_first_param;
    logic                   m_first_present;
    logic [OUT_PARAM_W-1:0] m_second_param;
    logic                   m_second_present;

    ansi_escape_sequence_parser dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command        (m_command),
        .m_first_param    (m_first_param),
        .m_first_present  (m_first_present),
        .m_second_param   (m_second_param),
        .m_second_present (m_second_present)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    result_t     pending_cmds[$];
    phase_t      prs_phase;
    logic [15:0] arg1;
    logic [15:0] arg2;
    logic        arg1_seen;
    logic        arg2_seen;

    int          bytes_sent = 0;
    int          cmds_checked = 0;
    int          mismatches = 0;
    int          burst_left = 0;
    int          long_hold_cycles = 0;
    int          holds_done = 0;
    bit          gaps_off = 1'b0;
    logic [19:0] cmds_seen = '0;

    task automatic reset_parser_model();
        prs_phase = PH_IDLE;
        arg1      = '0;
        arg1_seen = 1'b0;
        arg2      = '0;
        arg2_seen = 1'b0;
    endtask

    function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] b);
        int unsigned v;
        v = acc;
        v = v * 10 + (b - CH_ZERO);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic digit_byte(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // Advances the model by one accepted byte and queues any command it ends.
    task automatic parse_byte(input logic [7:0] b);
        logic        ends_seq;
        logic        has_cmd;
        logic [4:0]  cmd;
        logic [15:0] arg;
        result_t     res;
        ends_seq = 1'b0;
        case (prs_phase)
            PH_IDLE: begin
                if (b == CH_ESC) begin
                    reset_parser_model();
                    prs_phase = PH_ESC;
                end
            end
            PH_ESC: begin
                if (b == CH_LBR) prs_phase = PH_FIRST;
                else ends_seq = 1'b1;
            end
            PH_FIRST: begin
                if (digit_byte(b)) begin
                    arg1      = add_digit(arg1, b);
                    arg1_seen = 1'b1;
                end else if (b == CH_SEMI) begin
                    arg2_seen = 1'b1;
                    prs_phase = PH_SECOND;
                end else begin
                    ends_seq = 1'b1;
                end
            end
            default: begin
                if (digit_byte(b)) arg2 = add_digit(arg2, b);
                else ends_seq = 1'b1;
            end
        endcase
        if (ends_seq) begin
            arg     = arg1_seen ? arg1 : 16'd0;
            has_cmd = 1'b1;
            cmd     = CMD_UP;
            case (b)
                CH_A:        cmd = CMD_UP;
                CH_B:        cmd = CMD_DOWN;
                CH_C:        cmd = CMD_RIGHT;
                CH_D:        cmd = CMD_LEFT;
                CH_E:        cmd = CMD_NEXTLINE;
                CH_F:        cmd = CMD_PREVLINE;
                CH_G:        cmd = CMD_COLUMN;
                CH_H:        cmd = arg1_seen ? CMD_MOVETO : CMD_HOME;
                CH_LF:       cmd = CMD_MOVETO;
                CH_M:        cmd = CMD_LINEUP;
                CH_7, CH_LS: cmd = CMD_SAVE;
                CH_8, CH_LU: cmd = CMD_RESTORE;
                CH_J: begin
                    if (arg <= 16'd3) cmd = CMD_ERASE_SCREEN_BASE + arg[4:0];
                    else has_cmd = 1'b0;
                end
                CH_K: begin
                    if (arg <= 16'd2) cmd = CMD_ERASE_LINE_BASE + arg[4:0];
                    else has_cmd = 1'b0;
                end
                CH_LM:       cmd = CMD_STYLE;
                default:     has_cmd = 1'b0;
            endcase
            prs_phase = PH_IDLE;
            if (has_cmd) begin
                res.command        = cmd;
                res.first_param    = arg;
                res.first_present  = arg1_seen;
                res.second_param   = arg2_seen ? arg2 : 16'd0;
                res.second_present = arg2_seen;
                pending_cmds.push_back(res);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!gaps_off && burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                    : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid   <= 1'b0;
                s_rx_byte <= 8'($urandom);
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_seq(input string body);
        send_byte(CH_ESC);
        for (int i = 0; i < body.len(); i++) send_byte(body[i]);
    endtask

    task automatic send_number(input int ndig);
        for (int i = 0; i < ndig; i++) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] pick_final(input int idx);
        case (idx)
            0:  return CH_A;
            1:  return CH_B;
            2:  return CH_C;
            3:  return CH_D;
            4:  return CH_E;
            5:  return CH_F;
            6:  return CH_G;
            7:  return CH_H;
            8:  return CH_LF;
            9:  return CH_M;
            10: return CH_7;
            11: return CH_8;
            12: return CH_LS;
            13: return CH_LU;
            14: return CH_J;
            15: return CH_K;
            default: return CH_LM;
        endcase
    endfunction

    function automatic int pick_digit_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 0;
        if (r < 7) return 1;
        if (r < 9) return $urandom_range(2, 3);
        return $urandom_range(4, 7);
    endfunction

    task automatic send_random_csi();
        send_byte(CH_ESC);
        send_byte(CH_LBR);
        send_number(pick_digit_count());
        if ($urandom_range(0, 2) == 0) begin
            send_byte(CH_SEMI);
            send_number(pick_digit_count());
        end
        if ($urandom_range(0, 6) == 0) send_byte(8'($urandom_range(0, 255)));
        else send_byte(pick_final($urandom_range(0, 16)));
    endtask

    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_seq("7");
        send_seq("8");
        send_seq("5");
        send_seq("H");
        send_seq("[H");
        send_seq("[3;H");
        send_seq("[65535;65536f");
        send_seq("[99999A");
        send_seq("[4J");
        send_seq("[3J");
        send_seq("[K");
        send_seq("[3K");
        send_seq("[1;2;m");
        send_seq("[5");
        send_byte(CH_ESC);
        send_byte(CH_A);
        send_seq("[;7m");
        send_seq("[x");
    endtask

    task automatic test_random_stream(input int target);
        int kind;
        int n;
        while (bytes_sent < target) begin
            kind = $urandom_range(0, 19);
            if (kind < 15) begin
                send_random_csi();
            end else if (kind < 17) begin
                send_byte(CH_ESC);
                case ($urandom_range(0, 2))
                    0: send_byte(pick_final($urandom_range(0, 16)));
                    1: send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                    default: send_byte(8'($urandom_range(0, 255)));
                endcase
            end else begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_backpressure();
        gaps_off = 1'b1;
        long_hold_cycles = 300;
        repeat (20) send_seq("7");
        repeat (10) send_random_csi();
        gaps_off = 1'b0;
    endtask

    initial begin : receiver
        int mode;
        int seg_left;
        int stall_left;
        mode       = 0;
        seg_left   = 0;
        stall_left = 0;
        m_ready    = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (long_hold_cycles != 0) begin
                stall_left       = long_hold_cycles;
                long_hold_cycles = 0;
                holds_done++;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(0, 7);
                            m_ready <= 1'b0;
                        end else begin
                            m_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t ns: unexpected command transaction, expected none, actual %0d",
                         $time, m_command);
                mismatches++;
            end else begin
                want = pending_cmds.pop_front();
                compare_field("command", 16'(want.command), 16'(m_command));
                compare_field("first_param", want.first_param, m_first_param);
                compare_field("first_present", 16'(want.first_present), 16'(m_first_present));
                compare_field("second_param", want.second_param, m_second_param);
                compare_field("second_present", 16'(want.second_present),
                              16'(m_second_present));
                if (want.command < 20) cmds_seen[want.command] = 1'b1;
                cmds_checked++;
            end
        end
    end

    initial begin
        #5ms;
        $display("Timeout with %0d commands outstanding", pending_cmds.size());
        $display("Verification failed");
        $finish;
    end

    initial begin : main
        int waited;
        $timeformat(-9, 0, "", 0);
        s_valid   = 1'b0;
        s_rx_byte = 8'h00;
        reset_parser_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_stream(500);
        test_backpressure();
        test_random_stream(950);
        s_valid <= 1'b0;
        waited = 0;
        while (pending_cmds.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (pending_cmds.size() != 0) begin
            $display("%0t ns: %0d commands never arrived, expected 0, actual %0d",
                     $time, pending_cmds.size(), pending_cmds.size());
            mismatches++;
        end
        $display("Sent %0d bytes and checked %0d commands of %0d distinct kinds,",
                 bytes_sent, cmds_checked, $countones(cmds_seen));
        $display("with %0d long receiver hold and %0d mismatches.", holds_done, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/aesp_pkg.sv
rtl/core/aesp_step.sv
rtl/core/ansi_escape_sequence_parser.sv
test/tb_top.sv
